FILE: rtl/core/rsi_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and width helpers for the ray-sphere intersection core.
package rsi_pkg;

  localparam int unsigned RSI_COORD_WIDTH = 32;
  localparam int unsigned RSI_FRAC_BITS   = 16;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_NO_ROOT  = 2'd1,
    ST_BEHIND   = 2'd2,
    ST_ZERO_DIR = 2'd3
  } rsi_status_e;

  typedef struct packed {
    rsi_status_e status;
    logic        near;
  } rsi_ctl_t;

  // a = d.d
  function automatic int unsigned rsi_aw(int unsigned cw);
    return 2 * cw;
  endfunction

  // b = (o-c).d, signed
  function automatic int unsigned rsi_bw(int unsigned cw);
    return 2 * cw + 2;
  endfunction

  // k = |o-c|^2 - r^2, signed
  function automatic int unsigned rsi_kw(int unsigned cw);
    return 2 * cw + 3;
  endfunction

  // magnitude of b^2 - a*k
  function automatic int unsigned rsi_dmw(int unsigned cw);
    return 4 * cw + 3;
  endfunction

  // square root bits of disc * 2^(2*fb)
  function automatic int unsigned rsi_sw(int unsigned cw, int unsigned fb);
    return (rsi_dmw(cw) + 2 * fb + 1) >> 1;
  endfunction

  // signed numerator width
  function automatic int unsigned rsi_numw(int unsigned cw, int unsigned fb);
    int unsigned xw;
    int unsigned sw;
    xw = rsi_bw(cw) + fb;
    sw = rsi_sw(cw, fb);
    return ((xw > sw) ? xw : sw) + 2;
  endfunction

endpackage

FILE: rtl/core/rsi_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for ray items and intersection results.
interface rsi_in_if #(
  parameter int unsigned CW = rsi_pkg::RSI_COORD_WIDTH
);
  logic          valid;
  logic          ready;
  logic [CW-1:0] origin_x;
  logic [CW-1:0] origin_y;
  logic [CW-1:0] origin_z;
  logic [CW-1:0] dir_x;
  logic [CW-1:0] dir_y;
  logic [CW-1:0] dir_z;
  logic [CW-1:0] center_x;
  logic [CW-1:0] center_y;
  logic [CW-1:0] center_z;
  logic [CW-2:0] radius;

  modport source (
    output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           center_x, center_y, center_z, radius,
    input  ready
  );
  modport sink (
    input  valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
           center_x, center_y, center_z, radius,
    output ready
  );
endinterface

interface rsi_out_if #(
  parameter int unsigned CW = rsi_pkg::RSI_COORD_WIDTH
);
  logic          valid;
  logic          ready;
  logic [1:0]    status;
  logic [CW-2:0] hit_param;

  modport source (output valid, status, hit_param, input ready);
  modport sink (input valid, status, hit_param, output ready);
endinterface

FILE: rtl/core/ray_sphere_intersect_core.sv
`timescale 1ns / 1ps
// Ray-sphere intersection core: streaming nearest-hit parameter with status.
// Accepts one ray/sphere item per clock while the output is not held and
// returns one result per item, in order. The square root pipeline gives one
// root bit per stage, S = (4*COORD_WIDTH + 2*FRAC_BITS + 4) / 2 root bits in
// all, and is followed by the divider, one quotient bit per stage. A single
// enable stalls the whole pipe while a result waits at the output; nothing is
// dropped or repeated. Status is hit, no real root, sphere behind the ray, or
// zero direction; hit_param is zero unless hit and saturates to the largest
// Q-format value.
module ray_sphere_intersect_core #(
  parameter int unsigned COORD_WIDTH = rsi_pkg::RSI_COORD_WIDTH,
  parameter int unsigned FRAC_BITS   = rsi_pkg::RSI_FRAC_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rsi_in_if.sink      in_i,
  rsi_out_if.source   out_o
);
  import rsi_pkg::*;

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned FB = FRAC_BITS;
  localparam int unsigned AW = rsi_aw(CW);
  localparam int unsigned BW = rsi_bw(CW);
  localparam int unsigned KW = rsi_kw(CW);
  localparam int unsigned DMW = rsi_dmw(CW);
  localparam int unsigned SW = rsi_sw(CW, FB);

  logic                 en;
  logic [2:0][CW-1:0]   org, dir, ctr;

  logic                 c_vld;
  logic [AW-1:0]        c_a;
  logic signed [BW-1:0] c_b;
  logic signed [KW-1:0] c_k;

  logic                 d_vld;
  logic [DMW-1:0]       d_dm;
  rsi_ctl_t             d_ctl;
  logic [AW-1:0]        d_a;
  logic signed [BW-1:0] d_nb;

  logic                 s_vld;
  logic [SW-1:0]        s_root;
  logic                 s_exact;
  rsi_ctl_t             s_ctl;
  logic [AW-1:0]        s_a;
  logic signed [BW-1:0] s_nb;

  logic                 q_vld;
  rsi_status_e          q_status;
  logic                 q_sat;
  logic [CW-2:0]        q_quo;

  logic                 out_valid_q;
  rsi_status_e          status_q;
  logic [CW-2:0]        hit_param_d, hit_param_q;

  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  assign org = {in_i.origin_z, in_i.origin_y, in_i.origin_x};
  assign dir = {in_i.dir_z, in_i.dir_y, in_i.dir_x};
  assign ctr = {in_i.center_z, in_i.center_y, in_i.center_x};

  rsi_coef #(.CW(CW)) u_coef (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid),
    .org_i   (org),
    .dir_i   (dir),
    .ctr_i   (ctr),
    .rad_i   (in_i.radius),
    .valid_o (c_vld),
    .a_o     (c_a),
    .b_o     (c_b),
    .k_o     (c_k)
  );

  rsi_disc #(.CW(CW)) u_disc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c_vld),
    .a_i     (c_a),
    .b_i     (c_b),
    .k_i     (c_k),
    .valid_o (d_vld),
    .dm_o    (d_dm),
    .ctl_o   (d_ctl),
    .a_o     (d_a),
    .nb_o    (d_nb)
  );

  rsi_sqrt #(.CW(CW), .FB(FB)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_vld),
    .dm_i    (d_dm),
    .ctl_i   (d_ctl),
    .a_i     (d_a),
    .nb_i    (d_nb),
    .valid_o (s_vld),
    .s_o     (s_root),
    .exact_o (s_exact),
    .ctl_o   (s_ctl),
    .a_o     (s_a),
    .nb_o    (s_nb)
  );

  rsi_div #(.CW(CW), .FB(FB)) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (s_vld),
    .s_i      (s_root),
    .exact_i  (s_exact),
    .ctl_i    (s_ctl),
    .a_i      (s_a),
    .nb_i     (s_nb),
    .valid_o  (q_vld),
    .status_o (q_status),
    .sat_o    (q_sat),
    .q_o      (q_quo)
  );

  always_comb begin
    if (q_status != ST_HIT) begin
      hit_param_d = '0;
    end else if (q_sat) begin
      hit_param_d = '1;
    end else begin
      hit_param_d = q_quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= q_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      status_q    <= q_status;
      hit_param_q <= hit_param_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = status_q;
  assign out_o.hit_param = hit_param_q;

endmodule

FILE: rtl/core/rsi_coef.sv
`timescale 1ns / 1ps
// Three-stage front end: offset vector, products, and coefficients a, b, k.
module rsi_coef #(
  parameter int unsigned CW = rsi_pkg::RSI_COORD_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [2:0][CW-1:0]                org_i,
  input  logic [2:0][CW-1:0]                dir_i,
  input  logic [2:0][CW-1:0]                ctr_i,
  input  logic [CW-2:0]                     rad_i,
  output logic                              valid_o,
  output logic [rsi_pkg::rsi_aw(CW)-1:0]    a_o,
  output logic signed [rsi_pkg::rsi_bw(CW)-1:0] b_o,
  output logic signed [rsi_pkg::rsi_kw(CW)-1:0] k_o
);
  import rsi_pkg::*;

  localparam int unsigned VW = CW + 1;
  localparam int unsigned AW = rsi_aw(CW);
  localparam int unsigned BW = rsi_bw(CW);
  localparam int unsigned KW = rsi_kw(CW);

  logic                     vld1_q, vld2_q, vld3_q;
  logic signed [VW-1:0]     v_d [3], v_q [3];
  logic signed [CW-1:0]     d_q [3];
  logic [CW-2:0]            r_q;
  logic signed [2*CW-1:0]   dd_d [3], dd_q [3];
  logic signed [2*CW:0]     vd_d [3], vd_q [3];
  logic signed [2*VW-1:0]   vv_d [3], vv_q [3];
  logic [2*CW-3:0]          rr_d, rr_q;
  logic [AW-1:0]            a_d, a_q;
  logic signed [BW-1:0]     b_d, b_q;
  logic signed [KW-1:0]     k_d, k_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v_d[i]  = VW'($signed(org_i[i])) - VW'($signed(ctr_i[i]));
      dd_d[i] = d_q[i] * d_q[i];
      vd_d[i] = v_q[i] * d_q[i];
      vv_d[i] = v_q[i] * v_q[i];
    end
    rr_d = r_q * r_q;
    a_d  = AW'(dd_q[0]) + AW'(dd_q[1]) + AW'(dd_q[2]);
    b_d  = BW'(vd_q[0]) + BW'(vd_q[1]) + BW'(vd_q[2]);
    k_d  = KW'(vv_q[0]) + KW'(vv_q[1]) + KW'(vv_q[2]) - $signed(KW'(rr_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        v_q[i]  <= v_d[i];
        d_q[i]  <= $signed(dir_i[i]);
        dd_q[i] <= dd_d[i];
        vd_q[i] <= vd_d[i];
        vv_q[i] <= vv_d[i];
      end
      r_q  <= rad_i;
      rr_q <= rr_d;
      a_q  <= a_d;
      b_q  <= b_d;
      k_q  <= k_d;
    end
  end

  assign valid_o = vld3_q;
  assign a_o     = a_q;
  assign b_o     = b_q;
  assign k_o     = k_q;

endmodule

FILE: rtl/core/rsi_disc.sv
`timescale 1ns / 1ps
// Four-stage discriminant b^2 - a*k from split partial products, and item status.
module rsi_disc #(
  parameter int unsigned CW = rsi_pkg::RSI_COORD_WIDTH
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic [rsi_pkg::rsi_aw(CW)-1:0]        a_i,
  input  logic signed [rsi_pkg::rsi_bw(CW)-1:0] b_i,
  input  logic signed [rsi_pkg::rsi_kw(CW)-1:0] k_i,
  output logic                                  valid_o,
  output logic [rsi_pkg::rsi_dmw(CW)-1:0]       dm_o,
  output rsi_pkg::rsi_ctl_t                     ctl_o,
  output logic [rsi_pkg::rsi_aw(CW)-1:0]        a_o,
  output logic signed [rsi_pkg::rsi_bw(CW)-1:0] nb_o
);
  import rsi_pkg::*;

  localparam int unsigned AW  = rsi_aw(CW);
  localparam int unsigned BW  = rsi_bw(CW);
  localparam int unsigned KW  = rsi_kw(CW);
  localparam int unsigned BMW = BW - 1;
  localparam int unsigned KMW = KW - 1;
  localparam int unsigned BL  = (BMW + 1) / 2;
  localparam int unsigned BH  = BMW - BL;
  localparam int unsigned AL  = AW / 2;
  localparam int unsigned AH  = AW - AL;
  localparam int unsigned KL  = (KMW + 1) / 2;
  localparam int unsigned KH  = KMW - KL;
  localparam int unsigned B2W = 2 * BMW;
  localparam int unsigned AKW = AW + KMW;
  localparam int unsigned DW  = ((B2W > AKW) ? B2W : AKW) + 2;
  localparam int unsigned DMW = rsi_dmw(CW);

  typedef struct packed {
    logic azero;
    logic bpos;
    logic kneg;
    logic kpos;
  } flags_t;

  logic                 vld4_q, vld5_q, vld6_q, vld7_q;
  flags_t               fl_d, fl4_q, fl5_q, fl6_q;
  logic [BMW-1:0]       bm_d, bm_q;
  logic [KMW-1:0]       km_d, km_q;
  logic [AW-1:0]        a4_q, a5_q, a6_q, a7_q;
  logic signed [BW-1:0] nb_d, nb4_q, nb5_q, nb6_q, nb7_q;
  logic [2*BL-1:0]      bll_q;
  logic [BL+BH-1:0]     blh_q;
  logic [2*BH-1:0]      bhh_q;
  logic [AL+KL-1:0]     all_q;
  logic [AL+KH-1:0]     alh_q;
  logic [AH+KL-1:0]     ahl_q;
  logic [AH+KH-1:0]     ahh_q;
  logic [B2W-1:0]       b2_d, b2_q;
  logic [AKW-1:0]       ak_d, ak_q;
  logic signed [DW-1:0] disc_d;
  logic [DMW-1:0]       dm_q;
  rsi_ctl_t             ctl_d, ctl_q;

  always_comb begin
    fl_d.azero = (a_i == '0);
    fl_d.bpos  = !b_i[BW-1] && (b_i != '0);
    fl_d.kneg  = k_i[KW-1];
    fl_d.kpos  = !k_i[KW-1] && (k_i != '0);
    nb_d       = -b_i;
    bm_d       = b_i[BW-1] ? BMW'(nb_d) : BMW'(b_i);
    km_d       = k_i[KW-1] ? KMW'(-k_i) : KMW'(k_i);

    b2_d = (B2W'(bhh_q) << (2 * BL)) + (B2W'(blh_q) << (BL + 1)) + B2W'(bll_q);
    ak_d = (AKW'(ahh_q) << (AL + KL)) + (AKW'(ahl_q) << AL)
         + (AKW'(alh_q) << KL) + AKW'(all_q);

    disc_d = fl6_q.kneg ? (DW'(b2_q) + DW'(ak_q)) : (DW'(b2_q) - DW'(ak_q));
    ctl_d.near = !fl6_q.bpos && !fl6_q.kneg;
    if (fl6_q.azero) begin
      ctl_d.status = ST_ZERO_DIR;
    end else if (disc_d[DW-1]) begin
      ctl_d.status = ST_NO_ROOT;
    end else if (fl6_q.bpos && fl6_q.kpos) begin
      ctl_d.status = ST_BEHIND;
    end else begin
      ctl_d.status = ST_HIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld4_q <= 1'b0;
      vld5_q <= 1'b0;
      vld6_q <= 1'b0;
      vld7_q <= 1'b0;
    end else if (en_i) begin
      vld4_q <= valid_i;
      vld5_q <= vld4_q;
      vld6_q <= vld5_q;
      vld7_q <= vld6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fl4_q <= fl_d;
      bm_q  <= bm_d;
      km_q  <= km_d;
      a4_q  <= a_i;
      nb4_q <= nb_d;

      bll_q <= bm_q[BL-1:0] * bm_q[BL-1:0];
      blh_q <= bm_q[BL-1:0] * bm_q[BMW-1:BL];
      bhh_q <= bm_q[BMW-1:BL] * bm_q[BMW-1:BL];
      all_q <= a4_q[AL-1:0] * km_q[KL-1:0];
      alh_q <= a4_q[AL-1:0] * km_q[KMW-1:KL];
      ahl_q <= a4_q[AW-1:AL] * km_q[KL-1:0];
      ahh_q <= a4_q[AW-1:AL] * km_q[KMW-1:KL];
      fl5_q <= fl4_q;
      a5_q  <= a4_q;
      nb5_q <= nb4_q;

      b2_q  <= b2_d;
      ak_q  <= ak_d;
      fl6_q <= fl5_q;
      a6_q  <= a5_q;
      nb6_q <= nb5_q;

      dm_q  <= disc_d[DMW-1:0];
      ctl_q <= ctl_d;
      a7_q  <= a6_q;
      nb7_q <= nb6_q;
    end
  end

  assign valid_o = vld7_q;
  assign dm_o    = dm_q;
  assign ctl_o   = ctl_q;
  assign a_o     = a7_q;
  assign nb_o    = nb7_q;

endmodule

FILE: rtl/core/rsi_sqrt.sv
`timescale 1ns / 1ps
// Pipelined digit-by-digit square root of disc * 2^(2*FB), one root bit per stage.
module rsi_sqrt #(
  parameter int unsigned CW = rsi_pkg::RSI_COORD_WIDTH,
  parameter int unsigned FB = rsi_pkg::RSI_FRAC_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic [rsi_pkg::rsi_dmw(CW)-1:0]       dm_i,
  input  rsi_pkg::rsi_ctl_t                     ctl_i,
  input  logic [rsi_pkg::rsi_aw(CW)-1:0]        a_i,
  input  logic signed [rsi_pkg::rsi_bw(CW)-1:0] nb_i,
  output logic                                  valid_o,
  output logic [rsi_pkg::rsi_sw(CW, FB)-1:0]    s_o,
  output logic                                  exact_o,
  output rsi_pkg::rsi_ctl_t                     ctl_o,
  output logic [rsi_pkg::rsi_aw(CW)-1:0]        a_o,
  output logic signed [rsi_pkg::rsi_bw(CW)-1:0] nb_o
);
  import rsi_pkg::*;

  localparam int unsigned AW  = rsi_aw(CW);
  localparam int unsigned BW  = rsi_bw(CW);
  localparam int unsigned SW  = rsi_sw(CW, FB);
  localparam int unsigned NWE = 2 * SW;
  localparam int unsigned RW  = SW + 2;

  logic                 vld_q  [SW];
  logic [RW-1:0]        rem_q  [SW];
  logic [SW-1:0]        root_q [SW];
  logic [NWE-1:0]       nr_q   [SW];
  logic [AW-1:0]        a_q    [SW];
  logic signed [BW-1:0] nb_q   [SW];
  rsi_ctl_t             ctl_q  [SW];

  for (genvar j = 0; j < SW; j++) begin : g_stage
    logic                 vld_p;
    logic [RW-1:0]        rem_p;
    logic [SW-1:0]        root_p;
    logic [NWE-1:0]       nr_p;
    logic [AW-1:0]        a_p;
    logic signed [BW-1:0] nb_p;
    rsi_ctl_t             ctl_p;
    logic [RW+1:0]        r2;
    logic [RW+1:0]        trial;
    logic                 ge;

    if (j == 0) begin : g_first
      assign vld_p  = valid_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign nr_p   = NWE'(dm_i) << (2 * FB);
      assign a_p    = a_i;
      assign nb_p   = nb_i;
      assign ctl_p  = ctl_i;
    end else begin : g_next
      assign vld_p  = vld_q[j-1];
      assign rem_p  = rem_q[j-1];
      assign root_p = root_q[j-1];
      assign nr_p   = nr_q[j-1];
      assign a_p    = a_q[j-1];
      assign nb_p   = nb_q[j-1];
      assign ctl_p  = ctl_q[j-1];
    end

    always_comb begin
      r2    = {rem_p, nr_p[NWE-1 -: 2]};
      trial = (RW+2)'({root_p, 2'b01});
      ge    = (r2 >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? RW'(r2 - trial) : RW'(r2);
        root_q[j] <= {root_p[SW-2:0], ge};
        nr_q[j]   <= nr_p << 2;
        a_q[j]    <= a_p;
        nb_q[j]   <= nb_p;
        ctl_q[j]  <= ctl_p;
      end
    end
  end

  assign valid_o = vld_q[SW-1];
  assign s_o     = root_q[SW-1];
  assign exact_o = (rem_q[SW-1] == '0);
  assign ctl_o   = ctl_q[SW-1];
  assign a_o     = a_q[SW-1];
  assign nb_o    = nb_q[SW-1];

endmodule

FILE: rtl/core/rsi_div.sv
`timescale 1ns / 1ps
// Root numerator, saturation check and pipelined restoring division by a.
module rsi_div #(
  parameter int unsigned CW = rsi_pkg::RSI_COORD_WIDTH,
  parameter int unsigned FB = rsi_pkg::RSI_FRAC_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic [rsi_pkg::rsi_sw(CW, FB)-1:0]    s_i,
  input  logic                                  exact_i,
  input  rsi_pkg::rsi_ctl_t                     ctl_i,
  input  logic [rsi_pkg::rsi_aw(CW)-1:0]        a_i,
  input  logic signed [rsi_pkg::rsi_bw(CW)-1:0] nb_i,
  output logic                                  valid_o,
  output rsi_pkg::rsi_status_e                  status_o,
  output logic                                  sat_o,
  output logic [CW-2:0]                         q_o
);
  import rsi_pkg::*;

  localparam int unsigned AW   = rsi_aw(CW);
  localparam int unsigned NUMW = rsi_numw(CW, FB);
  localparam int unsigned QB   = CW - 1;
  localparam int unsigned CMPW = ((NUMW > AW + QB) ? NUMW : AW + QB) + 1;

  logic                   vldc_q, vlds_q;
  logic signed [NUMW-1:0] x;
  logic signed [NUMW-1:0] num_s;
  logic [NUMW-2:0]        num_q;
  rsi_status_e            stc_q, sts_q;
  logic [AW-1:0]          ac_q, as_q;
  logic                   sat_q;
  logic [AW-1:0]          rem0_q;
  logic [QB-1:0]          nl0_q;

  logic                   vld_q  [QB];
  logic [AW-1:0]          rem_q  [QB];
  logic [QB-1:0]          nl_q   [QB];
  logic [QB-1:0]          quo_q  [QB];
  logic [AW-1:0]          a_q    [QB];
  logic                   sat_sq [QB];
  rsi_status_e            st_q   [QB];

  always_comb begin
    x = NUMW'(nb_i) <<< FB;
    if (ctl_i.near) begin
      num_s = x - NUMW'(s_i) - NUMW'(!exact_i);
    end else begin
      num_s = x + NUMW'(s_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vldc_q <= 1'b0;
      vlds_q <= 1'b0;
    end else if (en_i) begin
      vldc_q <= valid_i;
      vlds_q <= vldc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q  <= num_s[NUMW-2:0];
      stc_q  <= ctl_i.status;
      ac_q   <= a_i;
      sat_q  <= (CMPW'(num_q) >= (CMPW'(ac_q) << QB));
      rem0_q <= AW'(num_q >> QB);
      nl0_q  <= num_q[QB-1:0];
      sts_q  <= stc_q;
      as_q   <= ac_q;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_stage
    logic          vld_p;
    logic [AW-1:0] rem_p;
    logic [QB-1:0] nl_p;
    logic [QB-1:0] quo_p;
    logic [AW-1:0] a_p;
    logic          sat_p;
    rsi_status_e   st_p;
    logic [AW:0]   r2;
    logic          ge;

    if (j == 0) begin : g_first
      assign vld_p = vlds_q;
      assign rem_p = rem0_q;
      assign nl_p  = nl0_q;
      assign quo_p = '0;
      assign a_p   = as_q;
      assign sat_p = sat_q;
      assign st_p  = sts_q;
    end else begin : g_next
      assign vld_p = vld_q[j-1];
      assign rem_p = rem_q[j-1];
      assign nl_p  = nl_q[j-1];
      assign quo_p = quo_q[j-1];
      assign a_p   = a_q[j-1];
      assign sat_p = sat_sq[j-1];
      assign st_p  = st_q[j-1];
    end

    always_comb begin
      r2 = {rem_p, nl_p[QB-1]};
      ge = (r2 >= {1'b0, a_p});
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? AW'(r2 - {1'b0, a_p}) : AW'(r2);
        nl_q[j]   <= nl_p << 1;
        quo_q[j]  <= {quo_p[QB-2:0], ge};
        a_q[j]    <= a_p;
        sat_sq[j] <= sat_p;
        st_q[j]   <= st_p;
      end
    end
  end

  assign valid_o  = vld_q[QB-1];
  assign status_o = st_q[QB-1];
  assign sat_o    = sat_sq[QB-1];
  assign q_o      = quo_q[QB-1];

endmodule

FILE: tb/rsi_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the ray-sphere core: exact-arithmetic hit prediction and in-order result compare.
module rsi_checker (
  input  logic clk_i,
  input  logic rst_ni,
  rsi_in_if    ray_w,
  rsi_out_if   res_w,
  output int   err_count_o,
  output int   pending_o
);
  import rsi_pkg::*;

  localparam int CW = RSI_COORD_WIDTH;
  localparam int FB = RSI_FRAC_BITS;

  typedef logic signed [255:0] big_t;

  typedef struct packed {
    rsi_status_e   status;
    logic [CW-2:0] hit_param;
  } hit_t;

  hit_t hit_q[$];

  function automatic logic [255:0] floor_sqrt(logic [255:0] n);
    logic [255:0] root;
    logic [255:0] cand;
    root = '0;
    for (int i = 127; i >= 0; i--) begin
      cand = root | (256'd1 << i);
      if (cand * cand <= n) root = cand;
    end
    return root;
  endfunction

  function automatic hit_t nearest_hit(logic [CW-1:0] o[3], logic [CW-1:0] d[3],
                                       logic [CW-1:0] c[3], logic [CW-2:0] r);
    big_t a;
    big_t b;
    big_t k;
    big_t v;
    big_t dv;
    big_t disc;
    big_t num;
    logic [255:0] n;
    logic [255:0] s;
    logic [255:0] q;
    logic b_pos;
    hit_t res;
    a = 0;
    b = 0;
    k = 0;
    for (int i = 0; i < 3; i++) begin
      dv = big_t'($signed(d[i]));
      v  = big_t'($signed(o[i])) - big_t'($signed(c[i]));
      a += dv * dv;
      b += v * dv;
      k += v * v;
    end
    k -= big_t'({1'b0, r}) * big_t'({1'b0, r});
    res.status    = ST_HIT;
    res.hit_param = '0;
    if (a == 0) begin
      res.status = ST_ZERO_DIR;
      return res;
    end
    disc = b * b - a * k;
    if (disc < 0) begin
      res.status = ST_NO_ROOT;
      return res;
    end
    b_pos = (b > 0);
    if (b_pos && k > 0) begin
      res.status = ST_BEHIND;
      return res;
    end
    num = -(b <<< FB);
    n   = disc <<< (2 * FB);
    s   = floor_sqrt(n);
    if (!b_pos && k >= 0) begin
      if (s * s != n) s = s + 1;
      num = num - big_t'(s);
    end else begin
      num = num + big_t'(s);
    end
    q = $unsigned(num) / $unsigned(a);
    if (q > ((256'd1 << (CW - 1)) - 1)) res.hit_param = '1;
    else res.hit_param = q[CW-2:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [CW-1:0] o[3];
    logic [CW-1:0] d[3];
    logic [CW-1:0] c[3];
    hit_t exp_h;
    if (!rst_ni) begin
      err_count_o <= 0;
    end else begin
      if (ray_w.valid && ray_w.ready) begin
        o = '{ray_w.origin_x, ray_w.origin_y, ray_w.origin_z};
        d = '{ray_w.dir_x, ray_w.dir_y, ray_w.dir_z};
        c = '{ray_w.center_x, ray_w.center_y, ray_w.center_z};
        hit_q.push_back(nearest_hit(o, d, c, ray_w.radius));
      end
      if (res_w.valid && res_w.ready) begin
        if (hit_q.size() == 0) begin
          $error("result with no item pending: status %0d hit_param %0h",
                 res_w.status, res_w.hit_param);
          err_count_o <= err_count_o + 1;
        end else begin
          exp_h = hit_q.pop_front();
          if (res_w.status !== exp_h.status) begin
            $error("status: expected %0d, got %0d", exp_h.status, res_w.status);
            err_count_o <= err_count_o + 1;
          end else if (res_w.hit_param !== exp_h.hit_param) begin
            $error("hit_param: expected %0h, got %0h", exp_h.hit_param, res_w.hit_param);
            err_count_o <= err_count_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = hit_q.size();

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Top-level testbench: ray stimulus, output back-pressure and pass/fail verdict.
module tb_top;
  import rsi_pkg::*;

  localparam int CW        = RSI_COORD_WIDTH;
  localparam int ONE       = 1 << RSI_FRAC_BITS;
  localparam int N_RANDOM  = 730;
  localparam int MAX_CYC   = 300000;
  localparam int DRAIN_CYC = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cyc = 0;
  int   err_count;
  int   pending;
  int   tx_idle_pct = 17;
  int   rx_idle_pct = 83;
  bit   rx_hold = 1'b0;

  rsi_in_if  ray_w ();
  rsi_out_if res_w ();

  ray_sphere_intersect_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (ray_w),
    .out_o  (res_w)
  );

  rsi_checker chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ray_w       (ray_w),
    .res_w       (res_w),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc >= MAX_CYC) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    res_w.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    ray_w.valid    = 1'b0;
    ray_w.origin_x = '0;
    ray_w.origin_y = '0;
    ray_w.origin_z = '0;
    ray_w.dir_x    = '0;
    ray_w.dir_y    = '0;
    ray_w.dir_z    = '0;
    ray_w.center_x = '0;
    ray_w.center_y = '0;
    ray_w.center_z = '0;
    ray_w.radius   = '0;
    res_w.ready    = 1'b0;
  end

  function automatic int near_coord();
    return int'($urandom_range(0, 1 << 24)) - (1 << 23);
  endfunction

  task automatic send_ray(int ox, int oy, int oz, int dx, int dy, int dz,
                          int cx, int cy, int cz, int unsigned r);
    ray_w.origin_x = ox;
    ray_w.origin_y = oy;
    ray_w.origin_z = oz;
    ray_w.dir_x    = dx;
    ray_w.dir_y    = dy;
    ray_w.dir_z    = dz;
    ray_w.center_x = cx;
    ray_w.center_y = cy;
    ray_w.center_z = cz;
    ray_w.radius   = r[CW-2:0];
    ray_w.valid    = 1'b1;
    do @(posedge clk_i); while (!ray_w.ready);
    @(negedge clk_i);
    if ($urandom_range(99) < tx_idle_pct) begin
      ray_w.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  task automatic send_random_ray();
    int o[3];
    int c[3];
    int d[3];
    int unsigned r;
    int sh;
    if ($urandom_range(9) == 0) begin
      send_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom, $urandom);
    end else begin
      r  = $urandom_range(0, 1 << 21);
      sh = $urandom_range(0, 8);
      for (int i = 0; i < 3; i++) begin
        c[i] = near_coord();
        o[i] = near_coord();
        d[i] = ((c[i] + int'($urandom_range(0, 2 * r)) - int'(r)) - o[i]) >>> sh;
      end
      if ($urandom_range(3) == 0) begin
        foreach (d[i]) d[i] = -d[i];
      end
      if ($urandom_range(7) == 0) begin
        foreach (o[i]) o[i] = c[i] + (int'($urandom_range(0, r)) >>> 1);
      end
      send_ray(o[0], o[1], o[2], d[0], d[1], d[2], c[0], c[1], c[2], r);
    end
  endtask

  task automatic wait_drained();
    ray_w.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_ray(0, 0, 0, 0, 0, 0, ONE, ONE, ONE, ONE);
    send_ray(-5 * ONE, 5 * ONE, 0, ONE, 0, 0, 0, 0, 0, ONE);
    send_ray(5 * ONE, 0, 0, ONE, 0, 0, 0, 0, 0, ONE);
    send_ray(0, 0, 0, ONE, 0, 0, 0, 0, 0, ONE);
    send_ray(-ONE, 0, 0, ONE, 0, 0, 0, 0, 0, ONE);
    send_ray(-5 * ONE, ONE, 0, ONE, 0, 0, 0, 0, 0, ONE);
    send_ray(-5 * ONE, 0, 0, ONE, 0, 0, 0, 0, 0, 0);
    send_ray(-5 * ONE, 0, 0, 1, 0, 0, 0, 0, 0, ONE);
    send_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
             32'h7fff_ffff, 32'h7fff_ffff);
    send_ray(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
             32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 32'h7fff_ffff);
    send_ray(32'h8000_0000, 0, 0, 32'h8000_0000, 0, 0, 32'h7fff_ffff, 0, 0,
             32'h7fff_ffff);
    send_ray(0, 0, 0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 0,
             32'h7fff_ffff);
    send_ray(0, 0, 3 * ONE, 0, 0, -1, 0, 0, 0, 2 * ONE);
    send_ray(ONE, ONE, ONE, -ONE, -ONE, -ONE, 0, 0, 0, ONE / 2);
    send_ray(-ONE, 0, 0, -ONE, 0, 0, 0, 0, 0, ONE);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) begin
        tx_idle_pct = 83;
        rx_idle_pct = 17;
      end
      if (n == 2 * N_RANDOM / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        fork
          begin
            rx_hold = 1'b1;
            repeat (400) @(negedge clk_i);
            rx_hold = 1'b0;
          end
        join_none
      end
      if (n == N_RANDOM / 2) wait_drained();
      send_random_ray();
    end

    wait_drained();
    repeat (DRAIN_CYC) @(negedge clk_i);
    if (err_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
